// File: rtl/mbrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Modbus response checker package
// Shared types, register indexes and status codes for the Modbus RTU
// response frame checker.
// ----------------------------------------------------------------------------
package mbrc_pkg;

    localparam int unsigned MAX_FRAME_DEFAULT = 16;

    localparam int unsigned POS_W   = 5;
    localparam int unsigned CRC_W   = 16;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [POS_W-1:0] LEN_RESET = 5'd9;
    localparam logic [POS_W-1:0] LEN_MIN   = 5'd4;
    localparam logic [CRC_W-1:0] POLY_RESET = 16'hA001;
    localparam logic [CRC_W-1:0] CRC_INIT   = 16'hFFFF;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_POLYNOMIAL  = 1'd1;

    // Byte-count codes of a response.
    localparam logic [7:0] COUNT_SHORT  = 8'd2;
    localparam logic [7:0] COUNT_LONG   = 8'd4;
    localparam logic [7:0] COUNT_DETAIL = 8'd8;

    // First and last frame positions held in the data window.
    localparam logic [POS_W-1:0] DATA_FIRST = 5'd3;
    localparam logic [POS_W-1:0] DATA_LAST  = 5'd10;

    typedef enum logic [2:0] {
        STATUS_CRC_BAD = 3'd0,
        STATUS_SHORT   = 3'd1,
        STATUS_LONG    = 3'd2,
        STATUS_DETAIL  = 3'd3,
        STATUS_OTHER   = 3'd4
    } status_t;

    typedef struct packed {
        logic [63:0]        detail_bytes;
        logic [31:0]        value_long;
        logic signed [15:0] value_short;
        status_t            status;
    } result_t;

endpackage : mbrc_pkg
`default_nettype wire

// File: rtl/mbrc_crc_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CRC byte step
// One byte of a reflected CRC-16 with a programmable polynomial, eight bit
// steps in combinational logic.
// ----------------------------------------------------------------------------
module mbrc_crc_step
    import mbrc_pkg::*;
(
    input  wire logic [CRC_W-1:0] crc_in,
    input  wire logic [7:0]       data_byte,
    input  wire logic [CRC_W-1:0] poly,
    output logic      [CRC_W-1:0] crc_out
);

    always_comb
    begin
        logic [CRC_W-1:0] c;
        c = crc_in ^ {8'd0, data_byte};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ poly;
            else
                c = c >> 1;
        end
        crc_out = c;
    end

endmodule : mbrc_crc_step
`default_nettype wire

// File: rtl/mbrc_out_skid.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result output stage
// Output register with a skid register behind it, so the input side keeps
// taking beats while one result waits downstream.
// ----------------------------------------------------------------------------
module mbrc_out_skid
    import mbrc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    res_valid,
    input  wire result_t res_data,
    output logic         can_take,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_data
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;

    // A new result only arrives while the skid register is empty.
    assign can_take  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || out_ready)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= res_valid;
                end
            end
            else if (res_valid)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (res_valid)
                out_data_reg <= res_data;
        end
        else if (res_valid)
        begin
            skid_data_reg <= res_data;
        end
    end

endmodule : mbrc_out_skid
`default_nettype wire

// File: rtl/modbus_response_frame_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Modbus RTU response frame checker
// Checks the CRC of a received response and decodes its data bytes.
// ----------------------------------------------------------------------------
// Takes one received byte per beat, with tuser marking the first byte of a
// frame. A reflected CRC-16 from all ones runs over every byte but the last
// two, which must match it low byte first. On the last byte of the frame
// (expected_length, clamped to 4..MAX_FRAME and to 31) one result beat goes
// out: a bad CRC status, or the data decoded by the byte count in byte 2.
// The byte-wide CRC update is combinational, so a byte can be taken in every
// cycle while s_tready is high. When the output is free, a result is written
// to the output register at the edge that takes its last byte, so m_tvalid
// is high in the next cycle. A second result may wait in a skid register
// while the output is stalled; while it waits, s_tready is low and no byte is
// taken until the output moves again. Bytes past the end of a frame are
// dropped until the next start.
// ----------------------------------------------------------------------------
module modbus_response_frame_checker
    import mbrc_pkg::*;
#(
    parameter int unsigned MAX_FRAME = MAX_FRAME_DEFAULT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Configuration write channel.
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // Received bytes.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,  // [7:0] rx_byte
    input  wire logic                  s_tuser,  // [0] frame_start
    // Results.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [15:0] value_short, [47:16] value_long, [111:48] detail_bytes
    output logic [111:0]               m_tdata,
    output logic [2:0]                 m_tuser   // [2:0] status
);

    localparam int unsigned     MAX_LEN   = (MAX_FRAME > 31) ? 31 : MAX_FRAME;
    localparam logic [POS_W-1:0] MAX_LEN_V = POS_W'(MAX_LEN);

    logic [POS_W-1:0] exp_len_reg;
    logic [CRC_W-1:0] poly_reg;

    logic [CRC_W-1:0] crc_reg,    crc_next;
    logic [POS_W-1:0] pos_reg,    pos_next;
    logic [7:0]       count_reg,  count_next;
    logic [63:0]      window_reg, window_next;
    logic [7:0]       crc_lo_reg, crc_lo_next;

    logic [CRC_W-1:0] crc_cur, crc_upd;
    logic [POS_W-1:0] pos_cur, len;
    logic [7:0]       count_cur, crc_lo_cur;
    logic [63:0]      window_cur;
    logic [2:0]       win_idx;

    logic             accept;
    logic             res_valid;
    result_t          res_data, out_data;
    logic             can_take;

    assign cfg_ready = 1'b1;
    assign s_tready  = can_take;
    assign accept    = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_len_reg <= LEN_RESET;
            poly_reg    <= POLY_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_EXPECTED_LENGTH: exp_len_reg <= cfg_data[POS_W-1:0];
                CFG_CRC_POLYNOMIAL:  poly_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (exp_len_reg < LEN_MIN)
            len = LEN_MIN;
        else if (exp_len_reg > MAX_LEN_V)
            len = MAX_LEN_V;
        else
            len = exp_len_reg;
    end

    // A frame start clears the frame state before this byte is used.
    assign crc_cur    = s_tuser ? CRC_INIT : crc_reg;
    assign pos_cur    = s_tuser ? '0 : pos_reg;
    assign count_cur  = s_tuser ? '0 : count_reg;
    assign window_cur = s_tuser ? '0 : window_reg;
    assign crc_lo_cur = s_tuser ? '0 : crc_lo_reg;
    assign win_idx    = 3'(pos_cur - DATA_FIRST);

    mbrc_crc_step u_crc_step
    (
        .crc_in    (crc_cur),
        .data_byte (s_tdata),
        .poly      (poly_reg),
        .crc_out   (crc_upd)
    );

    always_comb
    begin
        crc_next    = crc_cur;
        pos_next    = pos_cur;
        count_next  = count_cur;
        window_next = window_cur;
        crc_lo_next = crc_lo_cur;
        res_valid   = 1'b0;
        res_data    = '0;
        res_data.status = STATUS_CRC_BAD;

        if (pos_cur < len)
        begin
            if (pos_cur == 5'd2)
                count_next = s_tdata;
            for (int i = 0; i < 8; i++)
            begin
                if (pos_cur >= DATA_FIRST && pos_cur <= DATA_LAST && win_idx == 3'(i))
                    window_next[8*i +: 8] = s_tdata;
            end
            if (pos_cur < len - 5'd2)
                crc_next = crc_upd;
            else if (pos_cur == len - 5'd2)
                crc_lo_next = s_tdata;
            pos_next = pos_cur + 5'd1;

            if (pos_cur == len - 5'd1)
            begin
                res_valid = 1'b1;
                if (crc_lo_cur == crc_cur[7:0] && s_tdata == crc_cur[15:8])
                begin
                    case (count_cur)
                        COUNT_SHORT:
                        begin
                            res_data.status      = STATUS_SHORT;
                            res_data.value_short = {window_next[7:0], window_next[15:8]};
                        end
                        COUNT_LONG:
                        begin
                            res_data.status     = STATUS_LONG;
                            res_data.value_long = {window_next[7:0], window_next[15:8],
                                                   window_next[23:16], window_next[31:24]};
                        end
                        COUNT_DETAIL:
                        begin
                            res_data.status       = STATUS_DETAIL;
                            res_data.detail_bytes = window_next;
                        end
                        default:
                        begin
                            res_data.status = STATUS_OTHER;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg    <= CRC_INIT;
            pos_reg    <= '0;
            count_reg  <= '0;
            window_reg <= '0;
            crc_lo_reg <= '0;
        end
        else if (accept)
        begin
            crc_reg    <= crc_next;
            pos_reg    <= pos_next;
            count_reg  <= count_next;
            window_reg <= window_next;
            crc_lo_reg <= crc_lo_next;
        end
    end

    mbrc_out_skid u_out_skid
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (accept && res_valid),
        .res_data  (res_data),
        .can_take  (can_take),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {out_data.detail_bytes, out_data.value_long, out_data.value_short};
    assign m_tuser = out_data.status;

endmodule : modbus_response_frame_checker
`default_nettype wire
